FILE: sv/uwc_pkg.sv
// ============================================================================
// uwc_pkg
// Types and constants shared by the UTF-8 whitespace collapser modules.
// ============================================================================
package uwc_pkg;

    localparam int LEN_W  = 17;
    localparam int NBYTES = 5;

    localparam logic [7:0] CH_QMARK = 8'h3F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;

    // one input byte's worth of output, expanded by the back end
    typedef struct packed {
        logic [NBYTES-1:0][7:0] bytes;
        logic [2:0]             count;
        logic                   str_end;
        logic [LEN_W-1:0]       total_length;
    } uwc_desc_t;

endpackage

FILE: sv/uwc_front.sv
// ============================================================================
// uwc_front
// Decodes UTF-8, classifies space and builds at most one output descriptor per byte.
// ============================================================================
module uwc_front import uwc_pkg::*; #(
    parameter int MAX_STRING_BYTES = 65536
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_data_byte,
    input  logic       s_end_of_string,
    input  logic       no_embedded_newline,
    input  logic       q_full,
    output logic       q_push,
    output uwc_desc_t  q_desc
);

    localparam int CW = $clog2(MAX_STRING_BYTES + 1);

    logic            prev_space_reg, prev_space_next;
    logic            pend_nl_reg, pend_nl_next;
    logic [3:0][7:0] seq_reg, seq_next;
    logic [2:0]      cnt_reg, cnt_next;
    logic [2:0]      exp_reg, exp_next;
    logic [CW-1:0]   emitted_reg, emitted_next;

    logic [3:0][7:0] r;
    logic [2:0]      nr;
    logic            sp_hit, sp_lb, ok, in_seq, sep, accept;
    logic [20:0]     cp;
    logic [7:0]      b;
    logic [CW:0]     sum;

    assign s_ready = !q_full;
    assign accept  = s_valid && !q_full;
    assign b       = s_data_byte;

    always_comb begin
        seq_next = seq_reg;
        cnt_next = cnt_reg;
        exp_next = exp_reg;
        r        = '0;
        nr       = '0;
        sp_hit   = 1'b0;
        sp_lb    = 1'b0;
        ok       = 1'b0;
        cp       = '0;
        in_seq   = cnt_reg != 3'd0 && cnt_reg < 3'd4 && exp_reg > cnt_reg;
        if (in_seq && b[7:6] == 2'b10) begin
            seq_next[cnt_reg[1:0]] = b;
            cnt_next = cnt_reg + 3'd1;
            if (cnt_next == exp_reg) begin
                if (exp_reg == 3'd2) begin
                    cp = 21'({seq_next[0][4:0], seq_next[1][5:0]});
                    ok = cp >= 21'h80;
                end else if (exp_reg == 3'd3) begin
                    cp = 21'({seq_next[0][3:0], seq_next[1][5:0], seq_next[2][5:0]});
                    ok = cp >= 21'h800 && (cp < 21'hD800 || cp > 21'hDFFF);
                end else begin
                    cp = {seq_next[0][2:0], seq_next[1][5:0], seq_next[2][5:0],
                          seq_next[3][5:0]};
                    ok = cp >= 21'h10000 && cp < 21'h110000;
                end
                if (!ok) begin
                    for (int i = 0; i < 4; i++) begin
                        if (3'(i) < cnt_next) begin
                            r[nr[1:0]] = CH_QMARK;
                            nr = nr + 3'd1;
                        end
                    end
                end else if (cp == 21'h2028 || cp == 21'h2029) begin
                    sp_hit = 1'b1;
                    sp_lb  = 1'b1;
                end else if (cp == 21'hA0 || cp == 21'h1680 ||
                             (cp >= 21'h2000 && cp <= 21'h200A) ||
                             cp == 21'h202F || cp == 21'h205F || cp == 21'h3000) begin
                    sp_hit = 1'b1;
                end else begin
                    for (int i = 0; i < 4; i++) begin
                        if (3'(i) < exp_reg) begin
                            r[nr[1:0]] = seq_next[i];
                            nr = nr + 3'd1;
                        end
                    end
                end
                cnt_next = '0;
                exp_next = '0;
            end
        end else begin
            if (in_seq) begin
                for (int i = 0; i < 4; i++) begin
                    if (3'(i) < cnt_reg) begin
                        r[nr[1:0]] = CH_QMARK;
                        nr = nr + 3'd1;
                    end
                end
            end
            cnt_next = '0;
            exp_next = '0;
            if (!b[7]) begin
                if (b == CH_SPACE || (b >= 8'h09 && b <= CH_CR)) begin
                    sp_hit = 1'b1;
                    sp_lb  = b == CH_LF || b == CH_CR;
                end else begin
                    r[nr[1:0]] = b;
                    nr = nr + 3'd1;
                end
            end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
                seq_next[0] = b;
                cnt_next    = 3'd1;
                exp_next    = (b[7:5] == 3'b110) ? 3'd2 : (b[7:4] == 4'b1110) ? 3'd3 : 3'd4;
            end else begin
                r[nr[1:0]] = CH_QMARK;
                nr = nr + 3'd1;
            end
        end
        if (s_end_of_string) begin
            for (int i = 0; i < 4; i++) begin
                if (3'(i) < cnt_next) begin
                    r[nr[1:0]] = CH_QMARK;
                    nr = nr + 3'd1;
                end
            end
            cnt_next = '0;
            exp_next = '0;
        end
    end

    always_comb begin
        sep             = prev_space_reg && nr != 3'd0;
        prev_space_next = prev_space_reg && nr == 3'd0;
        pend_nl_next    = pend_nl_reg;
        if (sp_hit) begin
            pend_nl_next    = (sp_lb && !no_embedded_newline) ||
                              (prev_space_next && pend_nl_reg);
            prev_space_next = 1'b1;
        end
        q_desc = '0;
        if (sep) begin
            q_desc.bytes[0] = pend_nl_reg ? CH_LF : CH_SPACE;
        end
        for (int i = 0; i < 4; i++) begin
            q_desc.bytes[i + (sep ? 1 : 0)] = r[i];
        end
        q_desc.count = nr + {2'b00, sep};
        sum = {1'b0, emitted_reg} + (CW+1)'(q_desc.count);
        emitted_next = (sum >= (CW+1)'(MAX_STRING_BYTES)) ? CW'(MAX_STRING_BYTES)
                                                         : sum[CW-1:0];
        q_desc.str_end      = s_end_of_string;
        q_desc.total_length = s_end_of_string ? LEN_W'(emitted_next) : '0;
        if (s_end_of_string) begin
            prev_space_next = 1'b0;
            pend_nl_next    = 1'b0;
        end
        q_push = accept && (q_desc.count != 3'd0 || s_end_of_string);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_space_reg <= 1'b0;
            pend_nl_reg    <= 1'b0;
            cnt_reg        <= '0;
            exp_reg        <= '0;
            emitted_reg    <= '0;
        end else if (accept) begin
            prev_space_reg <= prev_space_next;
            pend_nl_reg    <= pend_nl_next;
            cnt_reg        <= cnt_next;
            exp_reg        <= exp_next;
            emitted_reg    <= s_end_of_string ? '0 : emitted_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            seq_reg <= seq_next;
        end
    end

endmodule

FILE: sv/uwc_queue.sv
// ============================================================================
// uwc_queue
// Four-entry descriptor queue between the front and back ends.
// ============================================================================
module uwc_queue import uwc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  uwc_desc_t push_desc,
    output logic      full,
    input  logic      pop,
    output logic      empty,
    output uwc_desc_t head
);

    uwc_desc_t  mem [4];
    logic [1:0] wr_reg, rd_reg;
    logic [2:0] fill_reg;

    assign full  = fill_reg == 3'd4;
    assign empty = fill_reg == 3'd0;
    assign head  = mem[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg   <= '0;
            rd_reg   <= '0;
            fill_reg <= '0;
        end else begin
            if (push) wr_reg <= wr_reg + 2'd1;
            if (pop) rd_reg <= rd_reg + 2'd1;
            fill_reg <= fill_reg + {2'b00, push} - {2'b00, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_reg] <= push_desc;
        end
    end

endmodule

FILE: sv/uwc_back.sv
// ============================================================================
// uwc_back
// Expands descriptors into one output byte per transaction.
// ============================================================================
module uwc_back import uwc_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_empty,
    input  uwc_desc_t        q_head,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_byte_valid,
    output logic             m_run_last,
    output logic             m_string_done,
    output logic [LEN_W-1:0] m_total_length
);

    logic             valid_reg;
    logic [2:0]       idx_reg;
    logic [7:0]       byte_reg;
    logic             bvalid_reg, last_reg, done_reg;
    logic [LEN_W-1:0] len_reg;
    logic             load, fire, last;

    assign load  = !valid_reg || m_ready;
    assign fire  = load && !q_empty;
    assign last  = q_head.count == 3'd0 || idx_reg == q_head.count - 3'd1;
    assign q_pop = fire && last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            if (load) valid_reg <= !q_empty;
            if (fire) idx_reg <= last ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            byte_reg   <= q_head.count == 3'd0 ? 8'h00 : q_head.bytes[idx_reg];
            bvalid_reg <= q_head.count != 3'd0;
            last_reg   <= last;
            done_reg   <= last && q_head.str_end;
            len_reg    <= (last && q_head.str_end) ? q_head.total_length : '0;
        end
    end

    assign m_valid        = valid_reg;
    assign m_out_byte     = byte_reg;
    assign m_byte_valid   = bvalid_reg;
    assign m_run_last     = last_reg;
    assign m_string_done  = done_reg;
    assign m_total_length = len_reg;

endmodule

FILE: sv/utf8_whitespace_collapser_core.sv
// ============================================================================
// utf8_whitespace_collapser_core
// Collapses UTF-8 white-space runs into single separators, byte in, byte out.
//
//   channel  dir  handshake               payload
//   s_       in   s_valid / s_ready       s_data_byte, s_end_of_string
//   m_       out  m_valid / m_ready       m_out_byte, m_byte_valid, m_run_last,
//                                         m_string_done, m_total_length
//   cfg_     in   cfg_valid / cfg_ready   cfg_data (no_embedded_newline)
//
// Front end takes one input byte per cycle, while the queue is not full, into a 4-deep queue.
// Back end sends one output byte per cycle while m_ready is high; a byte producing N results
// holds the back end for N output transactions (one for a bare end marker).
// Sustained rate: one input per cycle while outputs average one per input and m_ready stays high.
// Reset is synchronous on aresetn; either side may stall independently.
// ============================================================================
module utf8_whitespace_collapser_core import uwc_pkg::*; #(
    parameter int MAX_STRING_BYTES = 65536
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_data_byte,
    input  logic             s_end_of_string,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_byte_valid,
    output logic             m_run_last,
    output logic             m_string_done,
    output logic [LEN_W-1:0] m_total_length,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_data
);

    logic      nonl_reg;
    logic      q_push, q_full, q_pop, q_empty;
    uwc_desc_t q_in, q_head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nonl_reg <= 1'b0;
        end else if (cfg_valid) begin
            nonl_reg <= cfg_data;
        end
    end

    uwc_front #(.MAX_STRING_BYTES(MAX_STRING_BYTES)) u_front (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_data_byte         (s_data_byte),
        .s_end_of_string     (s_end_of_string),
        .no_embedded_newline (nonl_reg),
        .q_full              (q_full),
        .q_push              (q_push),
        .q_desc              (q_in)
    );

    uwc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_desc (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .head      (q_head)
    );

    uwc_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .q_empty        (q_empty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_byte_valid   (m_byte_valid),
        .m_run_last     (m_run_last),
        .m_string_done  (m_string_done),
        .m_total_length (m_total_length)
    );

endmodule
